>>> sv/kpfla_pkg.sv
`default_nettype none

package kpfla_pkg;

    // Default sizes of the link store and the head file.
    localparam int PAGE_UNITS_DEF   = 4096;
    localparam int SIZE_CLASSES_DEF = 8;

    // Field widths.
    localparam int PAGE_W  = 12;
    localparam int HEAD_W  = 13;
    localparam int CLASS_W = 3;
    localparam int UNITS_W = 5;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // A head or link word with the top bit set marks an empty list.
    localparam logic [HEAD_W-1:0] EMPTY_HEAD    = 13'h1000;
    localparam logic [HEAD_W-1:0] MAX_UNITS_RST = 13'd4096;

    typedef struct packed {
        logic               operation;
        logic [CLASS_W-1:0] size_class;
        logic [UNITS_W-1:0] block_units;
        logic [PAGE_W-1:0]  page;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0] page_out;
        logic              status;
        logic              unsorted_pages;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/kpfla_ram.sv
`default_nettype none

module kpfla_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/keypage_free_list_allocator.sv
`default_nettype none

// Page allocator with one LIFO free list per size class and a bump pointer
// for the file end. A transaction runs in two steps: in the first the
// class head is read and the link store is addressed with it, in the second
// the link store's registered read data comes back and the head, the link
// entry and the file end are written back. The output register holds the
// result, so a stalled result only delays the write-back step of the following
// transaction. The link store needs no clearing after reset; an entry is only
// popped after it was written by a free. PAGE_UNITS must be a power of two.
module keypage_free_list_allocator #(
    parameter int PAGE_UNITS   = kpfla_pkg::PAGE_UNITS_DEF,
    parameter int SIZE_CLASSES = kpfla_pkg::SIZE_CLASSES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire kpfla_pkg::t_in_item         i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output kpfla_pkg::t_out_item             o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [kpfla_pkg::HEAD_W-1:0] i_cfg_wdata
);

    localparam int LINK_AW = $clog2(PAGE_UNITS);
    localparam int CLS_IW  = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int HW      = kpfla_pkg::HEAD_W;

    typedef enum logic {
        S_IDLE,
        S_DONE
    } t_state;

    t_state                r_state;
    kpfla_pkg::t_in_item   r_item;
    logic [HW-1:0]         r_heads [SIZE_CLASSES];
    logic [HW-1:0]         r_file_end;
    logic [HW-1:0]         r_max_units;
    logic                  r_unsorted;
    logic                  r_out_valid;
    kpfla_pkg::t_out_item  r_out;

    logic                  in_acc;
    logic                  done;
    logic [7:0]            in_cls_ext;
    logic [7:0]            cur_cls_ext;
    logic [CLS_IW-1:0]     in_cls_idx;
    logic [CLS_IW-1:0]     cur_cls_idx;
    logic                  cls_ok;
    logic [HW-1:0]         in_head;
    logic [HW-1:0]         cur_head;
    logic [31:0]           rd_page_ext;
    logic [31:0]           wr_page_ext;
    logic [LINK_AW-1:0]    link_raddr;
    logic [LINK_AW-1:0]    link_waddr;
    logic [HW-1:0]         link_rdata;
    logic                  link_we;
    logic [HW:0]           bump_sum;
    logic                  is_free;
    logic                  is_pop;
    logic                  is_bump;
    logic                  is_full;
    logic [HW-1:0]         n_head;
    logic [HW-1:0]         n_file_end;
    logic                  n_unsorted;
    kpfla_pkg::t_out_item  n_out;

    // Class decode for the incoming item and for the item being finished.
    assign in_cls_ext  = 8'(i_in_data.size_class);
    assign cur_cls_ext = 8'(r_item.size_class);
    assign in_cls_idx  = in_cls_ext[CLS_IW-1:0];
    assign cur_cls_idx = cur_cls_ext[CLS_IW-1:0];
    assign cls_ok      = (cur_cls_ext < 8'(SIZE_CLASSES));

    assign in_head  = r_heads[in_cls_idx];
    assign cur_head = r_heads[cur_cls_idx];

    // Link store addressing: the page modulo the store depth.
    assign rd_page_ext = 32'(in_head[kpfla_pkg::PAGE_W-1:0]);
    assign wr_page_ext = 32'(r_item.page);
    assign link_raddr  = rd_page_ext[LINK_AW-1:0];
    assign link_waddr  = wr_page_ext[LINK_AW-1:0];

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign done       = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign link_we    = done && is_free;

    kpfla_ram #(
        .WIDTH(HW),
        .DEPTH(PAGE_UNITS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (cur_head),
        .i_re    (in_acc),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // Result and state update for the transaction in its write-back step.
    always_comb begin
        bump_sum   = (HW+1)'(r_file_end) + (HW+1)'(r_item.block_units);
        is_free    = (r_item.operation == kpfla_pkg::OP_FREE) && cls_ok;
        is_pop     = (r_item.operation == kpfla_pkg::OP_ALLOC) && cls_ok && !cur_head[HW-1];
        is_bump    = (r_item.operation == kpfla_pkg::OP_ALLOC) && cls_ok && cur_head[HW-1]
                     && (bump_sum < (HW+1)'(r_max_units));
        is_full    = (r_item.operation == kpfla_pkg::OP_ALLOC) && !is_pop && !is_bump;
        n_head     = cur_head;
        n_file_end = r_file_end;
        n_unsorted = r_unsorted;
        n_out.page_out = '0;
        n_out.status   = kpfla_pkg::ST_OK;
        priority if (r_item.operation == kpfla_pkg::OP_FREE) begin
            n_out.page_out = r_item.page;
            if (is_free) begin
                n_head     = HW'(r_item.page);
                n_unsorted = 1'b1;
            end
        end else if (is_pop) begin
            n_out.page_out = cur_head[kpfla_pkg::PAGE_W-1:0];
            n_head         = link_rdata;
            n_unsorted     = 1'b1;
        end else if (is_bump) begin
            n_out.page_out = r_file_end[kpfla_pkg::PAGE_W-1:0];
            n_file_end     = bump_sum[HW-1:0];
            n_unsorted     = 1'b1;
        end else begin
            n_out.status = kpfla_pkg::ST_FULL;
        end
        n_out.unsorted_pages = n_unsorted;
    end

    // Sequencer, state registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_file_end  <= '0;
            r_unsorted  <= 1'b0;
            r_max_units <= kpfla_pkg::MAX_UNITS_RST;
            for (int k = 0; k < SIZE_CLASSES; k++) begin
                r_heads[k] <= kpfla_pkg::EMPTY_HEAD;
            end
        end else begin
            if (i_cfg_we) begin
                r_max_units <= i_cfg_wdata;
            end
            // A finished write-back loads the output; otherwise an accepted result empties it.
            priority if (done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done) begin
                        r_state     <= S_IDLE;
                        r_file_end  <= n_file_end;
                        r_unsorted  <= n_unsorted;
                        if (is_free || is_pop) begin
                            r_heads[cur_cls_idx] <= n_head;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (done) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted transaction always moves on to its write-back cycle.
    a_acc_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DONE))
        else $error("accepted transaction did not reach write-back");

    // A new result appears only from a completed write-back cycle.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a write-back cycle");

    // The file end only grows while out of reset.
    a_end_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_file_end >= $past(r_file_end)))
        else $error("file end moved backward");

    // A full report never changes the file end.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && is_full) |=> $stable(r_file_end))
        else $error("full allocate changed the file end");

endmodule

`default_nettype wire

>>> verif/keypage_free_list_allocator_tb.sv
`timescale 1ns / 1ps

module keypage_free_list_allocator_tb;

    localparam int PAGE_W  = kpfla_pkg::PAGE_W;
    localparam int CLASS_W = kpfla_pkg::CLASS_W;
    localparam int UNITS_W = kpfla_pkg::UNITS_W;
    localparam int HEAD_W  = kpfla_pkg::HEAD_W;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned N_PHASES = 5;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CONFIG
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        kpfla_pkg::t_in_item   item;
        int unsigned           value;
        kpfla_pkg::t_out_item  want;
    } t_script_row;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [CLASS_W-1:0] cls;
    } t_owned_page;

    // DUT connections, all inputs known from time zero.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    kpfla_pkg::t_in_item  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    kpfla_pkg::t_out_item o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [HEAD_W-1:0]    i_cfg_wdata = '0;

    // Allocator state as the testbench sees it.
    logic [HEAD_W-1:0] class_heads [kpfla_pkg::SIZE_CLASSES_DEF];
    logic [HEAD_W-1:0] page_links [kpfla_pkg::PAGE_UNITS_DEF];
    logic [HEAD_W-1:0] file_end;
    logic [HEAD_W-1:0] max_units;
    logic              pages_touched;

    // Results still owed by the block, oldest first.
    kpfla_pkg::t_out_item owed_results [$];
    t_script_row          script_rows [$];
    t_owned_page          owned_pages [$];

    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned bump_count = 0;
    int unsigned pop_count = 0;
    int unsigned full_count = 0;
    int unsigned freed_count = 0;
    int unsigned cfg_writes = 0;
    int unsigned peak_file_end = 0;
    int unsigned sink_left = 0;
    int unsigned sink_gap;
    bit          source_quiet = 1'b0;
    bit          sink_quiet = 1'b0;
    bit          hold_off_req = 1'b0;

    int unsigned phase_max [0:N_PHASES-1] = '{0, 150, 1500, 8191, 4096};
    int unsigned phase_items [0:N_PHASES-1] = '{100, 200, 250, 400, 200};
    int unsigned phase_alloc_pct [0:N_PHASES-1] = '{60, 55, 55, 80, 50};
    bit          phase_big [0:N_PHASES-1] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    keypage_free_list_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones and a few long ones; none at all in quiet stretches.
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(99);
        if (quiet || r < 65) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // Applies one accepted transaction to the tracked state and returns its result.
    function automatic kpfla_pkg::t_out_item apply_page_op(kpfla_pkg::t_in_item it);
        kpfla_pkg::t_out_item res;
        logic [HEAD_W-1:0]    head;
        res = '0;
        res.status = kpfla_pkg::ST_OK;
        if (it.operation == kpfla_pkg::OP_FREE) begin
            res.page_out = it.page;
            page_links[it.page] = class_heads[it.size_class];
            class_heads[it.size_class] = {1'b0, it.page};
            pages_touched = 1'b1;
            freed_count++;
        end else begin
            head = class_heads[it.size_class];
            if (head == kpfla_pkg::EMPTY_HEAD) begin
                // The full test is done one bit wider so the sum cannot wrap.
                if (({1'b0, file_end} + 14'(it.block_units)) >= {1'b0, max_units}) begin
                    res.status = kpfla_pkg::ST_FULL;
                    full_count++;
                end else begin
                    res.page_out = file_end[PAGE_W-1:0];
                    file_end = file_end + HEAD_W'(it.block_units);
                    pages_touched = 1'b1;
                    bump_count++;
                    if (32'(file_end) > peak_file_end) begin
                        peak_file_end = 32'(file_end);
                    end
                end
            end else begin
                res.page_out = head[PAGE_W-1:0];
                class_heads[it.size_class] = page_links[head[PAGE_W-1:0]];
                pages_touched = 1'b1;
                pop_count++;
            end
        end
        res.unsorted_pages = pages_touched;
        return res;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void add_row(t_row_kind kind, logic op, int unsigned cls,
                                    int unsigned units, int unsigned value,
                                    int unsigned want_page, logic want_status,
                                    logic want_flag);
        t_script_row row;
        row.kind = kind;
        row.item.operation = op;
        row.item.size_class = CLASS_W'(cls);
        row.item.block_units = UNITS_W'(units);
        row.item.page = PAGE_W'(value);
        row.value = value;
        row.want.page_out = PAGE_W'(want_page);
        row.want.status = want_status;
        row.want.unsorted_pages = want_flag;
        script_rows.push_back(row);
    endfunction

    // Offers one transaction after a random gap and records its result once accepted.
    task automatic send_page_op(input kpfla_pkg::t_in_item it, input bit typed,
                                input kpfla_pkg::t_out_item typed_result,
                                output kpfla_pkg::t_out_item got);
        int unsigned gap;
        gap = pick_gap(source_quiet);
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        got = apply_page_op(it);
        owed_results.push_back(typed ? typed_result : got);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // The register is only written once every owed result has come back.
    task automatic write_max_units(int unsigned value);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= HEAD_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        max_units = HEAD_W'(value);
        cfg_writes++;
    endtask

    // Receiver: random stalls, with a long hold-off on request.
    always @(negedge i_clk) begin
        if (sink_left != 0) begin
            sink_left <= sink_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            sink_left <= HOLD_OFF_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            sink_gap = pick_gap(sink_quiet);
            sink_left <= (sink_gap != 0) ? sink_gap - 1 : 0;
            i_out_stall <= (sink_gap != 0);
        end
    end

    // Result checking and the watchdog.
    kpfla_pkg::t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    note_error($sformatf("unexpected result: page %0d status %0d flag %0d",
                        o_out_data.page_out, o_out_data.status, o_out_data.unsorted_pages));
                end else begin
                    want = owed_results.pop_front();
                    if (o_out_data.page_out !== want.page_out
                            || o_out_data.status !== want.status
                            || o_out_data.unsorted_pages !== want.unsorted_pages) begin
                        note_error($sformatf({"mismatch: expected page %0d status %0d ",
                            "flag %0d, got page %0d status %0d flag %0d"},
                            want.page_out, want.status, want.unsorted_pages,
                            o_out_data.page_out, o_out_data.status,
                            o_out_data.unsorted_pages));
                    end
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d results owed",
                    idle_cycles, owed_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus: directed script, then random phases under several limits.
    kpfla_pkg::t_in_item  it;
    kpfla_pkg::t_out_item got;
    t_owned_page          owned;
    int unsigned          r;
    int unsigned          idx;
    initial begin
        for (int c = 0; c < kpfla_pkg::SIZE_CLASSES_DEF; c++) begin
            class_heads[c] = kpfla_pkg::EMPTY_HEAD;
        end
        file_end = '0;
        max_units = kpfla_pkg::MAX_UNITS_RST;
        pages_touched = 1'b0;

        // A failed allocate before anything succeeded leaves the flag clear.
        add_row(ROW_CONFIG, kpfla_pkg::OP_ALLOC, 0, 0, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_TYPED, kpfla_pkg::OP_ALLOC, 0, 5, 0, 0, kpfla_pkg::ST_FULL, 1'b0);
        add_row(ROW_CONFIG, kpfla_pkg::OP_ALLOC, 0, 0, 4096, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_TYPED, kpfla_pkg::OP_ALLOC, 0, 16, 0, 0, kpfla_pkg::ST_OK, 1'b1);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 7, 1, 4095, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_TYPED, kpfla_pkg::OP_FREE, 3, 16, 4095, 4095, kpfla_pkg::ST_OK, 1'b1);
        add_row(ROW_PREDICT, kpfla_pkg::OP_FREE, 3, 16, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 3, 2, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 3, 2, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        // Zero block length hands out the file end twice.
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 3, 0, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 3, 0, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 5, 31, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_FREE, 7, 31, 'hAAA, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_FREE, 7, 31, 'h555, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 7, 9, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 7, 9, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        // File end exactly at the limit counts as full.
        add_row(ROW_CONFIG, kpfla_pkg::OP_ALLOC, 0, 0, 48, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_TYPED, kpfla_pkg::OP_ALLOC, 1, 0, 0, 0, kpfla_pkg::ST_FULL, 1'b1);
        add_row(ROW_PREDICT, kpfla_pkg::OP_FREE, 2, 1, 100, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_PREDICT, kpfla_pkg::OP_ALLOC, 2, 1, 0, 0, kpfla_pkg::ST_OK, 1'b0);
        add_row(ROW_TYPED, kpfla_pkg::OP_ALLOC, 2, 1, 0, 0, kpfla_pkg::ST_FULL, 1'b1);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[n]) begin
            if (script_rows[n].kind == ROW_CONFIG) begin
                write_max_units(script_rows[n].value);
            end else begin
                send_page_op(script_rows[n].item, script_rows[n].kind == ROW_TYPED,
                    script_rows[n].want, got);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_max_units(phase_max[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                if (k % 50 == 0) begin
                    source_quiet = ($urandom_range(3) == 0);
                    sink_quiet = ($urandom_range(3) == 0);
                end
                // Receiver holds off while transactions keep coming.
                if (k == phase_items[p] / 2) begin
                    hold_off_req = 1'b1;
                end
                // Sender pauses until everything owed has come back.
                if (k == (3 * phase_items[p]) / 4) begin
                    wait_results_drained();
                end
                it.page = PAGE_W'($urandom);
                it.size_class = CLASS_W'($urandom_range(kpfla_pkg::SIZE_CLASSES_DEF - 1));
                it.block_units = UNITS_W'($urandom_range(31));
                r = $urandom_range(99);
                if (r < phase_alloc_pct[p]) begin
                    it.operation = kpfla_pkg::OP_ALLOC;
                    if (phase_big[p]) begin
                        it.block_units = UNITS_W'($urandom_range(31, 20));
                    end else if ($urandom_range(9) < 8) begin
                        it.block_units = UNITS_W'(2 * it.size_class + 2);
                    end
                end else begin
                    it.operation = kpfla_pkg::OP_FREE;
                    // Mostly give back a page that was handed out, to its own class.
                    if (owned_pages.size() != 0 && $urandom_range(3) != 0) begin
                        idx = $urandom_range(owned_pages.size() - 1);
                        owned = owned_pages[idx];
                        owned_pages.delete(idx);
                        it.page = owned.page;
                        it.size_class = owned.cls;
                        it.block_units = UNITS_W'(2 * owned.cls + 2);
                    end
                end
                send_page_op(it, 1'b0, '0, got);
                if (it.operation == kpfla_pkg::OP_ALLOC && got.status == kpfla_pkg::ST_OK) begin
                    owned.page = got.page_out;
                    owned.cls = it.size_class;
                    owned_pages.push_back(owned);
                end
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d bump allocations, %0d list pops, %0d full answers, %0d frees",
            bump_count, pop_count, full_count, freed_count);
        $display("Across %0d limit settings; file end peaked at %0d units",
            cfg_writes, peak_file_end);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches in total", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> keypage_free_list_allocator.f
sv/kpfla_pkg.sv
sv/kpfla_ram.sv
sv/keypage_free_list_allocator.sv
verif/keypage_free_list_allocator_tb.sv
